// ===== rtl/kmp_first_match_finder_defines.svh =====
// assertion macros used by the checker file
`ifndef KMP_FIRST_MATCH_FINDER_DEFINES_SVH
`define KMP_FIRST_MATCH_FINDER_DEFINES_SVH

// checked only outside reset
`define KMPFM_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// checked through reset as well
`define KMPFM_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ===== rtl/kmpfm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package kmpfm_pkg;

    localparam int PATTERN_BYTES_DEF = 8;
    localparam int POSITION_BITS_DEF = 32;

    localparam int TEXT_W     = 8;
    localparam int START_W    = 32;
    localparam int PAT_W      = 64;
    localparam int LEN_W      = 4;
    localparam int CFG_ADDR_W = 1;

    // configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] CFG_PATTERN = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] CFG_LENGTH  = 1'b1;

    // per-transaction controls fanned out to every cell
    typedef struct packed {
        logic load;   // first byte of a text: latch the pattern byte
        logic step;   // byte consumed while still searching
        logic clear;  // last byte of a text
    } t_cell_ctrl;

endpackage

`default_nettype wire

// ===== rtl/kmp_first_match_finder.sv =====
`timescale 1ns / 1ps
// channel | dir | handshake                       | payload
// s       | in  | i_s_tvalid / o_s_tready         | tdata: text_byte; tlast: last_byte
// m       | out | o_m_tvalid / i_m_tready         | tdata: match_start; tuser: found
// cfg     | in  | i_cfg_valid / o_cfg_ready       | addr: register index; data: value
//
// one text byte per cycle while o_s_tready is high; each moves the match flags one cell along.
// a result sits in the output register in the cycle after the byte that causes it.
// o_s_tready is low only while a result waits and i_m_tready is low.
// i_rst_n is synchronous, active low; no clearing pass, the block is ready right after reset.
// the pattern and length are latched at the first byte of each text.
`default_nettype none

module kmp_first_match_finder #(
    parameter int PATTERN_BYTES = kmpfm_pkg::PATTERN_BYTES_DEF,
    parameter int POSITION_BITS = kmpfm_pkg::POSITION_BITS_DEF
) (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire                               i_s_tvalid,
    output logic                              o_s_tready,
    input  wire  [kmpfm_pkg::TEXT_W-1:0]      i_s_tdata,   // [7:0] text_byte
    input  wire                               i_s_tlast,
    output logic                              o_m_tvalid,
    input  wire                               i_m_tready,
    output logic [kmpfm_pkg::START_W-1:0]     o_m_tdata,   // [31:0] match_start
    output logic                              o_m_tuser,   // [0] found
    input  wire                               i_cfg_valid,
    output logic                              o_cfg_ready,
    input  wire  [kmpfm_pkg::CFG_ADDR_W-1:0]  i_cfg_addr,
    input  wire  [kmpfm_pkg::PAT_W-1:0]       i_cfg_data
);

    localparam int LW = (PATTERN_BYTES > 1) ? $clog2(PATTERN_BYTES) : 1;

    logic [kmpfm_pkg::PAT_W-1:0] r_cfg_pat;
    logic [kmpfm_pkg::LEN_W-1:0] r_cfg_len;
    logic                        r_active;
    logic                        r_done;
    logic [LW-1:0]               r_len_idx;
    logic [POSITION_BITS-1:0]    r_pos;
    logic                        r_out_valid;
    logic                        r_out_found;
    logic [kmpfm_pkg::START_W-1:0] r_out_start;

    logic                        w_accept;
    logic                        w_match;
    logic                        w_not_found;
    logic [LW-1:0]               w_cfg_idx;
    logic [LW-1:0]               w_len_idx;
    logic [POSITION_BITS-1:0]    w_pos_inc;
    logic [POSITION_BITS-1:0]    w_start;
    logic [kmpfm_pkg::START_W-1:0] w_start32;
    logic [PATTERN_BYTES-1:0]    w_hit;
    logic [PATTERN_BYTES-1:0]    w_next_hit;
    kmpfm_pkg::t_cell_ctrl       w_ctrl;

    assign o_cfg_ready = 1'b1;
    assign o_s_tready  = !r_out_valid || i_m_tready;
    assign w_accept    = i_s_tvalid && o_s_tready;

    always_comb begin
        if (r_cfg_len == '0) begin
            w_cfg_idx = '0;
        end else if (r_cfg_len > kmpfm_pkg::LEN_W'(PATTERN_BYTES)) begin
            w_cfg_idx = LW'(PATTERN_BYTES - 1);
        end else begin
            w_cfg_idx = LW'(r_cfg_len - 4'd1);
        end
    end

    assign w_len_idx = r_active ? r_len_idx : w_cfg_idx;

    assign w_ctrl.load  = w_accept && !r_active;
    assign w_ctrl.step  = w_accept && !r_done;
    assign w_ctrl.clear = w_accept && i_s_tlast;

    genvar k;
    generate
        for (k = 0; k < PATTERN_BYTES; k++) begin : g_cell
            logic w_prev;
            if (k == 0) begin : g_head
                assign w_prev = 1'b1;
            end else begin : g_link
                assign w_prev = w_hit[k-1];
            end
            kmpfm_cell u_cell (
                .i_clk      (i_clk),
                .i_rst_n    (i_rst_n),
                .i_ctrl     (w_ctrl),
                .i_cfg_byte (r_cfg_pat[8*k +: 8]),
                .i_byte     (i_s_tdata),
                .i_prev_hit (w_prev),
                .o_hit      (w_hit[k]),
                .o_next_hit (w_next_hit[k])
            );
        end
    endgenerate

    assign w_match     = w_ctrl.step && w_next_hit[w_len_idx];
    assign w_not_found = w_ctrl.clear && !r_done && !w_match;
    assign w_pos_inc   = (&r_pos) ? r_pos : r_pos + POSITION_BITS'(1);
    assign w_start     = r_pos - POSITION_BITS'(w_len_idx);

    generate
        if (POSITION_BITS >= kmpfm_pkg::START_W) begin : g_start_trunc
            assign w_start32 = w_start[kmpfm_pkg::START_W-1:0];
        end else begin : g_start_ext
            assign w_start32 = {{(kmpfm_pkg::START_W - POSITION_BITS){1'b0}}, w_start};
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_pat <= '0;
            r_cfg_len <= kmpfm_pkg::LEN_W'(1);
        end else if (i_cfg_valid) begin
            unique case (i_cfg_addr)
                kmpfm_pkg::CFG_PATTERN: r_cfg_pat <= i_cfg_data;
                kmpfm_pkg::CFG_LENGTH:  r_cfg_len <= i_cfg_data[kmpfm_pkg::LEN_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active  <= 1'b0;
            r_done    <= 1'b0;
            r_len_idx <= '0;
            r_pos     <= '0;
        end else if (w_accept) begin
            if (!r_active) begin
                r_len_idx <= w_cfg_idx;
            end
            if (i_s_tlast) begin
                r_active <= 1'b0;
                r_done   <= 1'b0;
                r_pos    <= '0;
            end else begin
                r_active <= 1'b1;
                r_done   <= r_done || w_match;
                r_pos    <= w_pos_inc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_match || w_not_found) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_match) begin
            r_out_found <= 1'b1;
            r_out_start <= w_start32;
        end else if (w_not_found) begin
            r_out_found <= 1'b0;
            r_out_start <= '0;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_start;
    assign o_m_tuser  = r_out_found;

endmodule

`default_nettype wire

// ===== rtl/kmpfm_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none

module kmpfm_cell (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire kmpfm_pkg::t_cell_ctrl i_ctrl,
    input  wire [kmpfm_pkg::TEXT_W-1:0] i_cfg_byte,
    input  wire [kmpfm_pkg::TEXT_W-1:0] i_byte,
    input  wire                        i_prev_hit,
    output logic                       o_hit,
    output logic                       o_next_hit
);

    logic [kmpfm_pkg::TEXT_W-1:0] r_pat;
    logic                         r_hit;
    logic [kmpfm_pkg::TEXT_W-1:0] w_pat;

    // the pattern byte is latched on the first byte of a text but used right away
    assign w_pat      = i_ctrl.load ? i_cfg_byte : r_pat;
    // prefix through this cell matched, ending at the current byte
    assign o_next_hit = i_prev_hit & (i_byte == w_pat);
    assign o_hit      = r_hit;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_pat <= i_cfg_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit <= 1'b0;
        end else if (i_ctrl.clear) begin
            r_hit <= 1'b0;
        end else if (i_ctrl.step) begin
            r_hit <= o_next_hit;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/kmpfm_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "kmp_first_match_finder_defines.svh"

module kmpfm_checker (
    input wire                              i_clk,
    input wire                              i_rst_n,
    input wire                              i_s_tvalid,
    input wire                              o_s_tready,
    input wire                              o_m_tvalid,
    input wire                              i_m_tready,
    input wire [kmpfm_pkg::START_W-1:0]     o_m_tdata,
    input wire                              o_m_tuser
);

    // a waiting result holds its payload
    `KMPFM_ASSERT(a_out_hold, o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser), "result changed while stalled")
    // a not-found result carries a zero start
    `KMPFM_ASSERT(a_miss_zero, o_m_tvalid && !o_m_tuser |-> o_m_tdata == '0, "not-found result with nonzero start")
    // a new result only follows an accepted byte
    `KMPFM_ASSERT(a_out_cause, $rose(o_m_tvalid) |-> $past(i_s_tvalid && o_s_tready), "result without input transaction")
    // reset empties the output register
    `KMPFM_ASSERT_RST(a_rst_empty, !i_rst_n |=> !o_m_tvalid, "output valid after reset")

endmodule

bind kmp_first_match_finder kmpfm_checker u_kmpfm_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_s_tvalid  (i_s_tvalid),
    .o_s_tready  (o_s_tready),
    .o_m_tvalid  (o_m_tvalid),
    .i_m_tready  (i_m_tready),
    .o_m_tdata   (o_m_tdata),
    .o_m_tuser   (o_m_tuser)
);

`default_nettype wire
